// ----- hdl/dsivd_pkg.sv -----
// Package for the DSI video symbol deframer: codes, types and fixed field widths.
// Used by every module of the deframer and by its port checker; depends on nothing.

package dsivd_pkg;

    // Fixed field widths of the item formats.
    localparam int TIME_W     = 48;
    localparam int BYTE_W     = 8;
    localparam int PIX_W      = 16;
    localparam int S_TDATA_W  = 104;
    localparam int S_TUSER_W  = 4;
    localparam int M_TDATA_W  = 144;
    localparam int M_TUSER_W  = 3;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [PIX_W-1:0] PIX_MAX = '1;

    // Symbol kinds on the input channel; codes above end of capture count as other.
    typedef enum logic [3:0] {
        K_VC      = 4'd0,
        K_ID      = 4'd1,
        K_DATA    = 4'd2,
        K_ECC_OK  = 4'd3,
        K_ECC_BAD = 4'd4,
        K_CRC_OK  = 4'd5,
        K_CRC_BAD = 4'd6,
        K_OTHER   = 4'd7,
        K_EOC     = 4'd8
    } sym_kind_t;

    // Event kinds on the result channel.
    typedef enum logic [2:0] {
        EV_VSYNC  = 3'd0,
        EV_HSYNC  = 3'd1,
        EV_PIXEL  = 3'd2,
        EV_EXTEND = 3'd3,
        EV_LINE   = 3'd4
    } evt_kind_t;

    // Packet parser states.
    typedef enum logic [2:0] {
        PS_IDLE      = 3'd0,
        PS_ID        = 3'd1,
        PS_EXTEND    = 3'd2,
        PS_RGB_START = 3'd3,
        PS_RGB_RED   = 3'd4,
        PS_RGB_GREEN = 3'd5,
        PS_RGB_BLUE  = 3'd6
    } parse_state_t;

    // Kind of the most recent sync or pixel event.
    typedef enum logic [1:0] {
        LE_NONE  = 2'd0,
        LE_VSYNC = 2'd1,
        LE_HSYNC = 2'd2,
        LE_PIXEL = 2'd3
    } last_evt_t;

    // Line checksum status.
    typedef enum logic [1:0] {
        CS_NONE = 2'd0,
        CS_OK   = 2'd1,
        CS_BAD  = 2'd2
    } chk_status_t;

    // Register indexes (word address bits of the configuration port).
    localparam logic [2:0] REG_VSYNC_START = 3'd0;
    localparam logic [2:0] REG_HSYNC_START = 3'd1;
    localparam logic [2:0] REG_VSYNC_END   = 3'd2;
    localparam logic [2:0] REG_HSYNC_END   = 3'd3;
    localparam logic [2:0] REG_RGB888      = 3'd4;

    // Register reset values.
    localparam logic [7:0] RST_VSYNC_START = 8'd1;
    localparam logic [7:0] RST_HSYNC_START = 8'd33;
    localparam logic [7:0] RST_VSYNC_END   = 8'd17;
    localparam logic [7:0] RST_HSYNC_END   = 8'd49;
    localparam logic [7:0] RST_RGB888      = 8'd62;

    // Data type codes handed from the register block to the parser.
    typedef struct packed {
        logic [7:0] vsync_start;
        logic [7:0] hsync_start;
        logic [7:0] vsync_end;
        logic [7:0] hsync_end;
        logic [7:0] rgb888;
    } dt_codes_t;

    // One result item.
    typedef struct packed {
        evt_kind_t         kind;
        logic [TIME_W-1:0] t_start;
        logic [TIME_W-1:0] t_end;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [PIX_W-1:0]  pixels;
        chk_status_t       cs;
    } event_t;

endpackage

// ----- hdl/dsivd_cfg_regs.sv -----
// APB-style register block holding the five data type codes of the deframer.
// Depends on dsivd_pkg for register indexes, reset values and the code struct.

module dsivd_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dsivd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [dsivd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [dsivd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    output dsivd_pkg::dt_codes_t                codes
);

    dsivd_pkg::dt_codes_t codes_reg;
    logic [2:0]           reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[dsivd_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign codes   = codes_reg;

    // Register writes; addresses past the last register are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codes_reg.vsync_start <= dsivd_pkg::RST_VSYNC_START;
            codes_reg.hsync_start <= dsivd_pkg::RST_HSYNC_START;
            codes_reg.vsync_end   <= dsivd_pkg::RST_VSYNC_END;
            codes_reg.hsync_end   <= dsivd_pkg::RST_HSYNC_END;
            codes_reg.rgb888      <= dsivd_pkg::RST_RGB888;
        end else if (wr_en) begin
            case (reg_idx)
                dsivd_pkg::REG_VSYNC_START: codes_reg.vsync_start <= pwdata[7:0];
                dsivd_pkg::REG_HSYNC_START: codes_reg.hsync_start <= pwdata[7:0];
                dsivd_pkg::REG_VSYNC_END:   codes_reg.vsync_end   <= pwdata[7:0];
                dsivd_pkg::REG_HSYNC_END:   codes_reg.hsync_end   <= pwdata[7:0];
                dsivd_pkg::REG_RGB888:      codes_reg.rgb888      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read mux.
    always_comb begin
        case (reg_idx)
            dsivd_pkg::REG_VSYNC_START: prdata = 32'(codes_reg.vsync_start);
            dsivd_pkg::REG_HSYNC_START: prdata = 32'(codes_reg.hsync_start);
            dsivd_pkg::REG_VSYNC_END:   prdata = 32'(codes_reg.vsync_end);
            dsivd_pkg::REG_HSYNC_END:   prdata = 32'(codes_reg.hsync_end);
            dsivd_pkg::REG_RGB888:      prdata = 32'(codes_reg.rgb888);
            default:                    prdata = '0;
        endcase
    end

endmodule

// ----- hdl/dsivd_parser.sv -----
// Packet parser of the deframer: state machine, pixel assembly and line tracking.
// Depends on dsivd_pkg; one symbol is consumed per accepted item.

module dsivd_parser #(
    parameter int TIME_BITS  = 48,
    parameter int COUNT_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             item_valid,
    input  logic [3:0]                       sym_kind,
    input  logic [dsivd_pkg::BYTE_W-1:0]     sym_byte,
    input  logic [dsivd_pkg::TIME_W-1:0]     sym_start,
    input  logic [dsivd_pkg::TIME_W-1:0]     sym_end,
    input  dsivd_pkg::dt_codes_t             codes,
    output logic                             evt_valid,
    output dsivd_pkg::event_t                evt
);

    localparam int TW     = (TIME_BITS < dsivd_pkg::TIME_W) ? TIME_BITS : dsivd_pkg::TIME_W;
    localparam int CW     = (COUNT_BITS > dsivd_pkg::PIX_W) ? COUNT_BITS : dsivd_pkg::PIX_W;
    localparam int TIME_W = dsivd_pkg::TIME_W;

    dsivd_pkg::parse_state_t state_reg, state_next;
    dsivd_pkg::last_evt_t    last_reg, last_next;
    logic [TW-1:0]           pkt_start_reg, pkt_start_next;
    logic [TW-1:0]           sync_start_reg, sync_start_next;
    logic [7:0]              red_reg, red_next;
    logic [7:0]              green_reg, green_next;
    logic                    line_open_reg, line_open_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic [TW-1:0]           line_start_reg, line_start_next;
    logic [TW-1:0]           line_end_reg, line_end_next;
    dsivd_pkg::chk_status_t  cs_reg, cs_next;

    logic [TW-1:0]           ts;
    logic [TW-1:0]           te;
    logic [COUNT_BITS-1:0]   count_inc;
    logic                    fire;

    // Pixel count as reported, saturated to the 16-bit field.
    function automatic logic [dsivd_pkg::PIX_W-1:0] sat_pix(input logic [COUNT_BITS-1:0] c);
        logic [CW-1:0] w;
        w = CW'(c);
        sat_pix = (w > CW'(dsivd_pkg::PIX_MAX)) ? dsivd_pkg::PIX_MAX : w[dsivd_pkg::PIX_W-1:0];
    endfunction

    assign ts        = sym_start[TW-1:0];
    assign te        = sym_end[TW-1:0];
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    assign evt_valid = item_valid && fire;

    // Next parse state.
    always_comb begin
        state_next = state_reg;
        if (sym_kind == dsivd_pkg::K_EOC) begin
            state_next = dsivd_pkg::PS_IDLE;
        end else begin
            case (state_reg)
                dsivd_pkg::PS_ID: begin
                    state_next = dsivd_pkg::PS_IDLE;
                    if (sym_kind == dsivd_pkg::K_ID) begin
                        if (sym_byte == codes.vsync_start || sym_byte == codes.hsync_start) begin
                            state_next = dsivd_pkg::PS_IDLE;
                        end else if (sym_byte == codes.hsync_end) begin
                            if (last_reg == dsivd_pkg::LE_HSYNC)
                                state_next = dsivd_pkg::PS_EXTEND;
                        end else if (sym_byte == codes.vsync_end) begin
                            if (last_reg == dsivd_pkg::LE_VSYNC)
                                state_next = dsivd_pkg::PS_EXTEND;
                        end else if (sym_byte == codes.rgb888) begin
                            state_next = dsivd_pkg::PS_RGB_START;
                        end
                    end
                end
                dsivd_pkg::PS_EXTEND: begin
                    if (sym_kind != dsivd_pkg::K_DATA)
                        state_next = dsivd_pkg::PS_IDLE;
                end
                dsivd_pkg::PS_RGB_START, dsivd_pkg::PS_RGB_RED: begin
                    if (sym_kind == dsivd_pkg::K_DATA)
                        state_next = dsivd_pkg::PS_RGB_GREEN;
                    else
                        state_next = dsivd_pkg::PS_RGB_RED;
                end
                dsivd_pkg::PS_RGB_GREEN: begin
                    if (sym_kind == dsivd_pkg::K_DATA)
                        state_next = dsivd_pkg::PS_RGB_BLUE;
                end
                dsivd_pkg::PS_RGB_BLUE: begin
                    if (sym_kind == dsivd_pkg::K_DATA)
                        state_next = dsivd_pkg::PS_RGB_RED;
                end
                default: ;
            endcase
            // A VC symbol always opens a new packet.
            if (sym_kind == dsivd_pkg::K_VC)
                state_next = dsivd_pkg::PS_ID;
        end
    end

    // Datapath state and the event of this item.
    always_comb begin
        last_next       = last_reg;
        pkt_start_next  = pkt_start_reg;
        sync_start_next = sync_start_reg;
        red_next        = red_reg;
        green_next      = green_reg;
        line_open_next  = line_open_reg;
        count_next      = count_reg;
        line_start_next = line_start_reg;
        line_end_next   = line_end_reg;
        cs_next         = cs_reg;
        fire            = 1'b0;
        evt             = '0;

        if (sym_kind == dsivd_pkg::K_EOC) begin
            // Close the open line, then return everything to reset.
            fire        = line_open_reg && (count_reg != '0);
            evt.kind    = dsivd_pkg::EV_LINE;
            evt.t_start = TIME_W'(line_start_reg);
            evt.t_end   = TIME_W'(line_end_reg);
            evt.pixels  = sat_pix(count_reg);
            evt.cs      = cs_reg;
            last_next       = dsivd_pkg::LE_NONE;
            pkt_start_next  = '0;
            sync_start_next = '0;
            red_next        = '0;
            green_next      = '0;
            line_open_next  = 1'b0;
            count_next      = '0;
            line_start_next = '0;
            line_end_next   = '0;
            cs_next         = dsivd_pkg::CS_NONE;
        end else begin
            case (state_reg)
                dsivd_pkg::PS_ID: begin
                    if (sym_kind == dsivd_pkg::K_ID) begin
                        if (sym_byte == codes.vsync_start) begin
                            fire            = 1'b1;
                            evt.kind        = dsivd_pkg::EV_VSYNC;
                            evt.t_start     = TIME_W'(pkt_start_reg);
                            evt.t_end       = TIME_W'(te);
                            last_next       = dsivd_pkg::LE_VSYNC;
                            sync_start_next = pkt_start_reg;
                        end else if (sym_byte == codes.hsync_start) begin
                            fire            = 1'b1;
                            evt.kind        = dsivd_pkg::EV_HSYNC;
                            evt.t_start     = TIME_W'(pkt_start_reg);
                            evt.t_end       = TIME_W'(te);
                            last_next       = dsivd_pkg::LE_HSYNC;
                            sync_start_next = pkt_start_reg;
                        end
                    end
                end
                dsivd_pkg::PS_EXTEND: begin
                    if (sym_kind == dsivd_pkg::K_ECC_OK || sym_kind == dsivd_pkg::K_ECC_BAD) begin
                        fire        = 1'b1;
                        evt.kind    = dsivd_pkg::EV_EXTEND;
                        evt.t_start = TIME_W'(sync_start_reg);
                        evt.t_end   = TIME_W'(te);
                    end
                end
                dsivd_pkg::PS_RGB_START, dsivd_pkg::PS_RGB_RED: begin
                    // The first symbol after the identifier opens the line.
                    if (state_reg == dsivd_pkg::PS_RGB_START) begin
                        line_open_next  = 1'b1;
                        count_next      = '0;
                        line_start_next = ts;
                        line_end_next   = ts;
                        cs_next         = dsivd_pkg::CS_NONE;
                    end
                    if (sym_kind == dsivd_pkg::K_DATA) begin
                        pkt_start_next = ts;
                        red_next       = sym_byte;
                    end else if (sym_kind == dsivd_pkg::K_CRC_OK) begin
                        cs_next = dsivd_pkg::CS_OK;
                    end else if (sym_kind == dsivd_pkg::K_CRC_BAD) begin
                        cs_next = dsivd_pkg::CS_BAD;
                    end
                end
                dsivd_pkg::PS_RGB_GREEN: begin
                    if (sym_kind == dsivd_pkg::K_DATA)
                        green_next = sym_byte;
                end
                dsivd_pkg::PS_RGB_BLUE: begin
                    if (sym_kind == dsivd_pkg::K_DATA) begin
                        count_next    = count_inc;
                        line_end_next = te;
                        last_next     = dsivd_pkg::LE_PIXEL;
                        fire          = 1'b1;
                        evt.kind      = dsivd_pkg::EV_PIXEL;
                        evt.t_start   = TIME_W'(pkt_start_reg);
                        evt.t_end     = TIME_W'(te);
                        evt.red       = red_reg;
                        evt.green     = green_reg;
                        evt.blue      = sym_byte;
                        evt.pixels    = sat_pix(count_inc);
                        evt.cs        = cs_reg;
                    end
                end
                default: ;
            endcase

            // A VC symbol closes the line as it stands after the step above.
            if (sym_kind == dsivd_pkg::K_VC) begin
                pkt_start_next = ts;
                fire           = line_open_next && (count_next != '0);
                evt            = '0;
                evt.kind       = dsivd_pkg::EV_LINE;
                evt.t_start    = TIME_W'(line_start_next);
                evt.t_end      = TIME_W'(line_end_next);
                evt.pixels     = sat_pix(count_next);
                evt.cs         = cs_next;
                line_open_next = 1'b0;
            end
        end
    end

    // State registers, updated once per accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= dsivd_pkg::PS_IDLE;
            last_reg       <= dsivd_pkg::LE_NONE;
            pkt_start_reg  <= '0;
            sync_start_reg <= '0;
            red_reg        <= '0;
            green_reg      <= '0;
            line_open_reg  <= 1'b0;
            count_reg      <= '0;
            line_start_reg <= '0;
            line_end_reg   <= '0;
            cs_reg         <= dsivd_pkg::CS_NONE;
        end else if (item_valid) begin
            state_reg      <= state_next;
            last_reg       <= last_next;
            pkt_start_reg  <= pkt_start_next;
            sync_start_reg <= sync_start_next;
            red_reg        <= red_next;
            green_reg      <= green_next;
            line_open_reg  <= line_open_next;
            count_reg      <= count_next;
            line_start_reg <= line_start_next;
            line_end_reg   <= line_end_next;
            cs_reg         <= cs_next;
        end
    end

endmodule

// ----- hdl/dsivd_out_buf.sv -----
// Result register with a skid stage between the parser and the output stream.
// Depends on dsivd_pkg for the event struct.

module dsivd_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  dsivd_pkg::event_t in_data,
    output logic              in_ready,
    output logic              out_valid,
    output dsivd_pkg::event_t out_data,
    input  logic              out_ready
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    dsivd_pkg::event_t out_data_reg;
    dsivd_pkg::event_t skid_data_reg;
    logic              pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign pop       = out_valid_reg && out_ready;

    // Valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end else if (in_valid) begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop)
                out_data_reg <= skid_data_reg;
        end else if (in_valid) begin
            if (out_valid_reg && !pop)
                skid_data_reg <= in_data;
            else
                out_data_reg <= in_data;
        end
    end

endmodule

// ----- hdl/dsi_video_symbol_deframer_core.sv -----
// A result item is registered in a two-entry result buffer and shown on m_axis from there.
// Throughput: one symbol per cycle while its skid entry is empty, so input stays accepted
// while one result waits downstream; the parser updates all its state once per symbol.
// Reset: aresetn is synchronous and active low; it empties the result buffer, returns
// the parser to idle with cleared line state and loads the default data type codes.
// Top level of the DSI video symbol deframer; uses dsivd_pkg and the dsivd_* modules.

module dsi_video_symbol_deframer_core #(
    parameter int TIME_BITS  = 48,
    parameter int COUNT_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Symbol input stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: symbol_byte[7:0], symbol_start[55:8], symbol_end[103:56]
    input  logic [dsivd_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // tuser: symbol_kind[3:0]
    input  logic [dsivd_pkg::S_TUSER_W-1:0]     s_axis_tuser,
    // Event output stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: event_start[47:0], event_end[95:48], red_value[103:96], green_value[111:104],
    //        blue_value[119:112], line_pixels[135:120], checksum_status[137:136], zero pad
    output logic [dsivd_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // tuser: event_kind[2:0]
    output logic [dsivd_pkg::M_TUSER_W-1:0]     m_axis_tuser,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dsivd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [dsivd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [dsivd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);

    dsivd_pkg::dt_codes_t codes;
    dsivd_pkg::event_t    evt;
    dsivd_pkg::event_t    out_evt;
    logic                 evt_valid;
    logic                 item_valid;

    assign item_valid = s_axis_tvalid && s_axis_tready;

    dsivd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .codes   (codes)
    );

    dsivd_parser #(
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .sym_kind   (s_axis_tuser),
        .sym_byte   (s_axis_tdata[7:0]),
        .sym_start  (s_axis_tdata[55:8]),
        .sym_end    (s_axis_tdata[103:56]),
        .codes      (codes),
        .evt_valid  (evt_valid),
        .evt        (evt)
    );

    dsivd_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (evt_valid),
        .in_data   (evt),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (out_evt),
        .out_ready (m_axis_tready)
    );

    // Pack the result item onto the stream.
    assign m_axis_tuser = out_evt.kind;
    assign m_axis_tdata = {6'b0, out_evt.cs, out_evt.pixels, out_evt.blue, out_evt.green,
                           out_evt.red, out_evt.t_end, out_evt.t_start};

endmodule

// ----- hdl/dsivd_checker.sv -----
// Port-level checker for the DSI video symbol deframer, bound to the top level.
// Depends on dsivd_pkg for widths and event kinds.

module dsivd_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [dsivd_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input logic [dsivd_pkg::M_TUSER_W-1:0]     m_axis_tuser
);

    // The result buffer comes out of reset empty.
    a_empty_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_axis_tvalid)
        else $error("result shown right after reset");

    // A stalled result stays on offer.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // Only defined event kinds leave the block.
    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tuser <= dsivd_pkg::EV_LINE)
        else $error("undefined event kind");

    // Sync and extend events carry no pixel, count or checksum bits.
    a_sync_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == dsivd_pkg::EV_VSYNC ||
                          m_axis_tuser == dsivd_pkg::EV_HSYNC ||
                          m_axis_tuser == dsivd_pkg::EV_EXTEND)
        |-> m_axis_tdata[143:96] == '0)
        else $error("sync event with pixel fields set");

    // Pixel and line events always count at least one pixel, with a defined status.
    a_line_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == dsivd_pkg::EV_PIXEL ||
                          m_axis_tuser == dsivd_pkg::EV_LINE)
        |-> m_axis_tdata[135:120] != '0 && m_axis_tdata[137:136] != 2'd3)
        else $error("pixel or line event with empty count or bad status");

endmodule

bind dsi_video_symbol_deframer_core dsivd_checker u_dsivd_checker (.*);

// ----- tb/sv/dsivd_event_checker_pkg.sv -----
// Event checker for the DSI video symbol deframer testbench: a predictor of the
// frame events that follow each accepted symbol, and a checker for the result items.
// Depends on dsivd_pkg for symbol kinds, event kinds, parser states and the event type.

package dsivd_event_checker_pkg;

    class deframer_event_checker;
        // Data type codes as last programmed into the block.
        dsivd_pkg::dt_codes_t               codes;

        // Parser copy.
        dsivd_pkg::parse_state_t            pstate;
        dsivd_pkg::last_evt_t               last_evt;
        logic [dsivd_pkg::TIME_W-1:0]       pkt_start;
        logic [dsivd_pkg::TIME_W-1:0]       sync_start;
        logic [dsivd_pkg::BYTE_W-1:0]       red_hold;
        logic [dsivd_pkg::BYTE_W-1:0]       green_hold;
        logic                               line_open;
        // The counter is as wide as the line_pixels field at the default COUNT_BITS.
        logic [dsivd_pkg::PIX_W-1:0]        pix_count;
        logic [dsivd_pkg::TIME_W-1:0]       line_start;
        logic [dsivd_pkg::TIME_W-1:0]       line_end;
        dsivd_pkg::chk_status_t             line_cs;

        dsivd_pkg::event_t                  expected_events[$];
        int                                 errors;
        int                                 events_seen;

        function new();
            codes = '{dsivd_pkg::RST_VSYNC_START, dsivd_pkg::RST_HSYNC_START,
                      dsivd_pkg::RST_VSYNC_END, dsivd_pkg::RST_HSYNC_END,
                      dsivd_pkg::RST_RGB888};
            errors = 0;
            events_seen = 0;
            clear_parser();
        endfunction

        // Returns every part of the parser and line state to its reset value.
        function void clear_parser();
            pstate     = dsivd_pkg::PS_IDLE;
            last_evt   = dsivd_pkg::LE_NONE;
            pkt_start  = '0;
            sync_start = '0;
            red_hold   = '0;
            green_hold = '0;
            line_open  = 1'b0;
            pix_count  = '0;
            line_start = '0;
            line_end   = '0;
            line_cs    = dsivd_pkg::CS_NONE;
        endfunction

        function void set_code(logic [2:0] idx, logic [7:0] value);
            case (idx)
                dsivd_pkg::REG_VSYNC_START: codes.vsync_start = value;
                dsivd_pkg::REG_HSYNC_START: codes.hsync_start = value;
                dsivd_pkg::REG_VSYNC_END:   codes.vsync_end   = value;
                dsivd_pkg::REG_HSYNC_END:   codes.hsync_end   = value;
                dsivd_pkg::REG_RGB888:      codes.rgb888      = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        function void push_event(dsivd_pkg::evt_kind_t k,
                                 logic [dsivd_pkg::TIME_W-1:0] t0,
                                 logic [dsivd_pkg::TIME_W-1:0] t1,
                                 logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                 logic [dsivd_pkg::PIX_W-1:0] px,
                                 dsivd_pkg::chk_status_t cs);
            dsivd_pkg::event_t e;
            e.kind    = k;
            e.t_start = t0;
            e.t_end   = t1;
            e.red     = r;
            e.green   = g;
            e.blue    = b;
            e.pixels  = px;
            e.cs      = cs;
            expected_events.insert(expected_events.size(), e);
        endfunction

        // A line with at least one pixel ends with a summary event.
        function void close_line();
            if (line_open && pix_count != '0) begin
                push_event(dsivd_pkg::EV_LINE, line_start, line_end, '0, '0, '0,
                           pix_count, line_cs);
            end
            line_open = 1'b0;
        endfunction

        // Called for each accepted symbol; queues the event it causes, if any.
        function void accept_symbol(logic [3:0] kind_raw, logic [7:0] data,
                                    logic [dsivd_pkg::TIME_W-1:0] ts,
                                    logic [dsivd_pkg::TIME_W-1:0] te);
            dsivd_pkg::sym_kind_t k;
            if (kind_raw > dsivd_pkg::K_EOC) begin
                k = dsivd_pkg::K_OTHER;
            end else begin
                k = dsivd_pkg::sym_kind_t'(kind_raw);
            end

            if (k == dsivd_pkg::K_EOC) begin
                close_line();
                clear_parser();
                return;
            end

            case (pstate)
                dsivd_pkg::PS_ID: begin
                    pstate = dsivd_pkg::PS_IDLE;
                    // Codes are tried in a fixed order, so colliding codes resolve here.
                    if (k == dsivd_pkg::K_ID) begin
                        if (data == codes.vsync_start) begin
                            push_event(dsivd_pkg::EV_VSYNC, pkt_start, te, '0, '0, '0, '0,
                                       dsivd_pkg::CS_NONE);
                            last_evt   = dsivd_pkg::LE_VSYNC;
                            sync_start = pkt_start;
                        end else if (data == codes.hsync_start) begin
                            push_event(dsivd_pkg::EV_HSYNC, pkt_start, te, '0, '0, '0, '0,
                                       dsivd_pkg::CS_NONE);
                            last_evt   = dsivd_pkg::LE_HSYNC;
                            sync_start = pkt_start;
                        end else if (data == codes.hsync_end) begin
                            if (last_evt == dsivd_pkg::LE_HSYNC) pstate = dsivd_pkg::PS_EXTEND;
                        end else if (data == codes.vsync_end) begin
                            if (last_evt == dsivd_pkg::LE_VSYNC) pstate = dsivd_pkg::PS_EXTEND;
                        end else if (data == codes.rgb888) begin
                            pstate = dsivd_pkg::PS_RGB_START;
                        end
                    end
                end
                dsivd_pkg::PS_EXTEND: begin
                    // Data bytes of the short packet are skipped until its ECC.
                    if (k == dsivd_pkg::K_ECC_OK || k == dsivd_pkg::K_ECC_BAD) begin
                        push_event(dsivd_pkg::EV_EXTEND, sync_start, te, '0, '0, '0, '0,
                                   dsivd_pkg::CS_NONE);
                        pstate = dsivd_pkg::PS_IDLE;
                    end else if (k != dsivd_pkg::K_DATA) begin
                        pstate = dsivd_pkg::PS_IDLE;
                    end
                end
                dsivd_pkg::PS_RGB_START, dsivd_pkg::PS_RGB_RED: begin
                    // The first symbol after the identifier opens the line.
                    if (pstate == dsivd_pkg::PS_RGB_START) begin
                        line_open  = 1'b1;
                        pix_count  = '0;
                        line_start = ts;
                        line_end   = ts;
                        line_cs    = dsivd_pkg::CS_NONE;
                        pstate     = dsivd_pkg::PS_RGB_RED;
                    end
                    if (k == dsivd_pkg::K_DATA) begin
                        pkt_start = ts;
                        red_hold  = data;
                        pstate    = dsivd_pkg::PS_RGB_GREEN;
                    end else if (k == dsivd_pkg::K_CRC_OK) begin
                        line_cs = dsivd_pkg::CS_OK;
                    end else if (k == dsivd_pkg::K_CRC_BAD) begin
                        line_cs = dsivd_pkg::CS_BAD;
                    end
                end
                dsivd_pkg::PS_RGB_GREEN: begin
                    if (k == dsivd_pkg::K_DATA) begin
                        green_hold = data;
                        pstate     = dsivd_pkg::PS_RGB_BLUE;
                    end
                end
                dsivd_pkg::PS_RGB_BLUE: begin
                    if (k == dsivd_pkg::K_DATA) begin
                        if (pix_count != dsivd_pkg::PIX_MAX) pix_count = pix_count + 1'b1;
                        line_end = te;
                        push_event(dsivd_pkg::EV_PIXEL, pkt_start, te, red_hold, green_hold,
                                   data, pix_count, line_cs);
                        last_evt = dsivd_pkg::LE_PIXEL;
                        pstate   = dsivd_pkg::PS_RGB_RED;
                    end
                end
                default: ;
            endcase

            // A VC symbol always starts a new packet and closes any open line.
            if (k == dsivd_pkg::K_VC) begin
                pkt_start = ts;
                pstate    = dsivd_pkg::PS_ID;
                close_line();
            end
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want) begin
                report($sformatf("event %0d %s: got 0x%0h, expected 0x%0h",
                                 events_seen, name, got, want));
            end
        endtask

        // Compares one result item with the oldest expected event.
        task check_event(logic [dsivd_pkg::M_TUSER_W-1:0] tuser,
                         logic [dsivd_pkg::M_TDATA_W-1:0] tdata);
            dsivd_pkg::event_t want;
            events_seen++;
            if (expected_events.size() == 0) begin
                report($sformatf("event %0d of kind %0d arrived with none expected",
                                 events_seen, tuser));
                return;
            end
            want = expected_events.pop_front();
            check_field("event_kind",      tuser,            want.kind);
            check_field("event_start",     tdata[47:0],      want.t_start);
            check_field("event_end",       tdata[95:48],     want.t_end);
            check_field("red_value",       tdata[103:96],    want.red);
            check_field("green_value",     tdata[111:104],   want.green);
            check_field("blue_value",      tdata[119:112],   want.blue);
            check_field("line_pixels",     tdata[135:120],   want.pixels);
            check_field("checksum_status", tdata[137:136],   want.cs);
            check_field("tdata padding",   tdata[143:138],   '0);
        endtask
    endclass

endpackage

// ----- tb/sv/dsi_video_symbol_deframer_core_tb.sv -----
// Top-level testbench for dsi_video_symbol_deframer_core: drives symbol items and
// register writes, and checks every event item against the predictor.
// Depends on dsivd_pkg, dsivd_event_checker_pkg and the deframer RTL.

module dsi_video_symbol_deframer_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIME_BITS  = 48;
    localparam int COUNT_BITS = 16;
    // Longest correct stretch without a handshake is the output hold-off.
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic [3:0]                   kind;
        logic [7:0]                   data;
        logic [dsivd_pkg::TIME_W-1:0] ts;
        logic [dsivd_pkg::TIME_W-1:0] te;
    } symbol_item_t;

    logic                                aclk          = 1'b0;
    logic                                aresetn       = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [dsivd_pkg::S_TDATA_W-1:0]     s_axis_tdata  = '0;
    logic [dsivd_pkg::S_TUSER_W-1:0]     s_axis_tuser  = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [dsivd_pkg::M_TDATA_W-1:0]     m_axis_tdata;
    logic [dsivd_pkg::M_TUSER_W-1:0]     m_axis_tuser;
    logic                                psel          = 1'b0;
    logic                                penable       = 1'b0;
    logic                                pwrite        = 1'b0;
    logic [dsivd_pkg::APB_ADDR_W-1:0]    paddr         = '0;
    logic [dsivd_pkg::APB_DATA_W-1:0]    pwdata        = '0;
    logic [dsivd_pkg::APB_DATA_W-1:0]    prdata;
    logic                                pready;

    dsivd_event_checker_pkg::deframer_event_checker sb = new();
    symbol_item_t                    symbol_q[$];
    // Starts close to the top so that the running symbol time wraps during the run.
    logic [dsivd_pkg::TIME_W-1:0]    time_now = 48'hFFFF_FFFF_C000;
    int                              send_idle_pct = 0;
    int                              recv_idle_pct = 0;
    int                              hold_left = 0;
    int                              stall_cycles = 0;

    dsi_video_symbol_deframer_core #(
        .TIME_BITS (TIME_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Result side: check accepted items, then choose tready for the next cycle.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            sb.check_event(m_axis_tuser, m_axis_tdata);
        end
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles in which no item moves on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || psel) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("dsi_video_symbol_deframer_core_tb: done, errors");
            $finish;
        end
    end

    function automatic logic [7:0] rand8();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [dsivd_pkg::TIME_W-1:0] rand_time();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[dsivd_pkg::TIME_W-1:0];
    endfunction

    function automatic void push_raw(logic [3:0] kind, logic [7:0] data,
                                     logic [dsivd_pkg::TIME_W-1:0] ts,
                                     logic [dsivd_pkg::TIME_W-1:0] te);
        symbol_item_t it;
        it.kind = kind;
        it.data = data;
        it.ts   = ts;
        it.te   = te;
        symbol_q.insert(symbol_q.size(), it);
    endfunction

    // Mostly a rising capture time; now and then arbitrary times over the full range.
    function automatic void push_sym(logic [3:0] kind, logic [7:0] data);
        logic [dsivd_pkg::TIME_W-1:0] ts;
        logic [dsivd_pkg::TIME_W-1:0] te;
        if ($urandom_range(9) == 0) begin
            ts = rand_time();
            te = rand_time();
        end else begin
            ts = time_now + dsivd_pkg::TIME_W'($urandom_range(8));
            te = ts + dsivd_pkg::TIME_W'($urandom_range(1, 30));
            time_now = te;
        end
        push_raw(kind, data, ts, te);
    endfunction

    function automatic logic [3:0] ecc_kind();
        return $urandom_range(1) ? dsivd_pkg::K_ECC_OK : dsivd_pkg::K_ECC_BAD;
    endfunction

    function automatic logic [3:0] crc_kind();
        return $urandom_range(1) ? dsivd_pkg::K_CRC_OK : dsivd_pkg::K_CRC_BAD;
    endfunction

    // One packet of random content; most are well formed, the rest noise or broken.
    function automatic void gen_packet();
        int sel;
        int n;
        sel = $urandom_range(99);
        push_sym(dsivd_pkg::K_VC, rand8());
        if (sel < 15) begin
            // Sync start short packet.
            push_sym(dsivd_pkg::K_ID,
                     $urandom_range(1) ? sb.codes.vsync_start : sb.codes.hsync_start);
            push_sym(dsivd_pkg::K_DATA, rand8());
            push_sym(dsivd_pkg::K_DATA, rand8());
            push_sym(ecc_kind(), rand8());
        end else if (sel < 32) begin
            // Sync end short packet, sometimes cut off before its ECC.
            push_sym(dsivd_pkg::K_ID,
                     $urandom_range(1) ? sb.codes.vsync_end : sb.codes.hsync_end);
            n = $urandom_range(2);
            repeat (n) push_sym(dsivd_pkg::K_DATA, rand8());
            if ($urandom_range(9) == 0) push_sym(dsivd_pkg::K_OTHER, rand8());
            push_sym(ecc_kind(), rand8());
        end else if (sel < 70) begin
            // RGB888 long packet with a few pixels and an optional checksum.
            push_sym(dsivd_pkg::K_ID, sb.codes.rgb888);
            if ($urandom_range(3) != 0) push_sym(ecc_kind(), rand8());
            n = $urandom_range(6);
            repeat (n) begin
                if ($urandom_range(15) == 0) push_sym(crc_kind(), rand8());
                push_sym(dsivd_pkg::K_DATA, rand8());
                if ($urandom_range(15) == 0) push_sym(ecc_kind(), rand8());
                push_sym(dsivd_pkg::K_DATA, rand8());
                push_sym(dsivd_pkg::K_DATA, rand8());
            end
            if ($urandom_range(7) == 0) begin
                repeat ($urandom_range(1, 2)) push_sym(dsivd_pkg::K_DATA, rand8());
            end
            if ($urandom_range(3) != 0) push_sym(crc_kind(), rand8());
        end else if (sel < 78) begin
            push_sym(dsivd_pkg::K_ID, rand8());
            push_sym(dsivd_pkg::K_DATA, rand8());
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) push_sym(4'($urandom_range(15)), rand8());
        end
        if ($urandom_range(24) == 0) push_sym(dsivd_pkg::K_EOC, rand8());
    endfunction

    function automatic void gen_random(int count);
        while (symbol_q.size() < count) gen_packet();
    endfunction

    // Short directed run on the reset codes.
    function automatic void gen_directed();
        // VSYNC start, then VSYNC end extending it to an ECC end earlier than its start.
        push_raw(dsivd_pkg::K_VC, 8'h00, 48'd0, 48'd1);
        push_raw(dsivd_pkg::K_ID, dsivd_pkg::RST_VSYNC_START, 48'd2, 48'd3);
        push_raw(dsivd_pkg::K_ECC_OK, 8'h00, 48'd4, 48'd5);
        push_raw(dsivd_pkg::K_VC, 8'hFF, 48'd100, 48'd101);
        push_raw(dsivd_pkg::K_ID, dsivd_pkg::RST_VSYNC_END, 48'd102, 48'd103);
        push_raw(dsivd_pkg::K_DATA, 8'h00, 48'd104, 48'd105);
        push_raw(dsivd_pkg::K_ECC_BAD, 8'hFF, 48'd106, 48'd0);
        // HSYNC start and its matching end.
        push_raw(dsivd_pkg::K_VC, 8'h5A, 48'd200, 48'd201);
        push_raw(dsivd_pkg::K_ID, dsivd_pkg::RST_HSYNC_START, 48'd202, 48'd203);
        push_raw(dsivd_pkg::K_VC, 8'hA5, 48'd300, 48'd301);
        push_raw(dsivd_pkg::K_ID, dsivd_pkg::RST_HSYNC_END, 48'd302, 48'd303);
        push_raw(dsivd_pkg::K_ECC_OK, 8'h00, 48'd304, 48'd305);
        // RGB888 line of two pixels with a bad checksum, then a high kind as other.
        push_raw(dsivd_pkg::K_VC, 8'h00, 48'd400, 48'd401);
        push_raw(dsivd_pkg::K_ID, dsivd_pkg::RST_RGB888, 48'd402, 48'd403);
        push_raw(dsivd_pkg::K_ECC_OK, 8'h00, 48'd404, 48'd405);
        push_raw(dsivd_pkg::K_DATA, 8'h00, 48'd406, 48'd407);
        push_raw(dsivd_pkg::K_DATA, 8'hFF, 48'd408, 48'd409);
        push_raw(dsivd_pkg::K_DATA, 8'h5A, 48'd410, 48'd411);
        push_raw(dsivd_pkg::K_CRC_BAD, 8'h00, 48'd412, 48'd413);
        push_raw(dsivd_pkg::K_DATA, 8'hFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        push_raw(dsivd_pkg::K_DATA, 8'hFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        push_raw(dsivd_pkg::K_DATA, 8'hFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        push_raw(4'hF, 8'hFF, 48'd500, 48'd501);
        push_raw(dsivd_pkg::K_VC, 8'h00, 48'd600, 48'd601);
        // An RGB888 packet cut by end of capture leaves an empty line: no event.
        push_raw(dsivd_pkg::K_ID, dsivd_pkg::RST_RGB888, 48'd602, 48'd603);
        push_raw(dsivd_pkg::K_EOC, 8'h00, 48'd604, 48'd605);
    endfunction

    // Sends every queued symbol, idling at random before each one.
    task automatic send_symbols();
        symbol_item_t it;
        while (symbol_q.size() != 0) begin
            it = symbol_q.pop_front();
            while ($urandom_range(99) < send_idle_pct) begin
                s_axis_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {it.te, it.ts, it.data};
            s_axis_tuser  <= it.kind;
            do @(posedge aclk); while (!s_axis_tready);
            sb.accept_symbol(it.kind, it.data, it.ts, it.te);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // Waits for every expected event, then lets the pipeline settle.
    task automatic wait_events_drained();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(logic [2:0] idx, logic [7:0] value);
        logic [31:0] junk;
        junk = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk[31:8], value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_code(idx, value);
        @(posedge aclk);
    endtask

    task automatic apb_read(logic [2:0] idx, output logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        value = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Writes all five data type codes and reads each one back.
    task automatic program_codes(dsivd_pkg::dt_codes_t c);
        logic [31:0] rd;
        logic [2:0]  idx[5];
        logic [7:0]  val[5];
        idx = '{dsivd_pkg::REG_VSYNC_START, dsivd_pkg::REG_HSYNC_START,
                dsivd_pkg::REG_VSYNC_END, dsivd_pkg::REG_HSYNC_END, dsivd_pkg::REG_RGB888};
        val = '{c.vsync_start, c.hsync_start, c.vsync_end, c.hsync_end, c.rgb888};
        for (int i = 0; i < 5; i++) apb_write(idx[i], val[i]);
        for (int i = 0; i < 5; i++) begin
            apb_read(idx[i], rd);
            if (rd !== {24'h0, val[i]}) begin
                sb.report($sformatf("register %0d read 0x%0h, expected 0x%0h",
                                    idx[i], rd, val[i]));
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed items on the reset codes, with no idling.
        gen_directed();
        send_symbols();
        wait_events_drained();

        // Extreme codes; the sender idles lightly and the receiver heavily.
        send_idle_pct = 37;
        recv_idle_pct = 82;
        program_codes('{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h3E});
        gen_random(450);
        send_symbols();
        // Sender pauses until every expected event has arrived.
        wait_events_drained();
        gen_random(450);
        send_symbols();
        wait_events_drained();

        // Colliding codes; idling swapped.
        send_idle_pct = 82;
        recv_idle_pct = 37;
        program_codes('{8'h44, 8'h44, 8'h2C, 8'h2C, 8'h3C});
        gen_random(500);
        send_symbols();
        wait_events_drained();

        // No idling, opened by a long output hold-off that fills the block.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_codes('{8'hFF, 8'h00, 8'h01, 8'hFE, 8'h55});
        hold_left = 400;
        gen_random(500);
        send_symbols();
        wait_events_drained();

        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("dsi_video_symbol_deframer_core_tb: done, clean");
        end else begin
            $display("dsi_video_symbol_deframer_core_tb: done, errors");
        end
        $finish;
    end

endmodule
